// File: hdl/tsr_pkg.sv
// Shared types, codes and defaults for the TCP segment reassembly unit.
// No dependencies; every other file in hdl but tsr_ram imports this package.
package tsr_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int HANDLE_BITS_DEF = 8;

  // Input command codes.
  localparam logic [1:0] CMD_OPEN   = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FIN    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result kinds.
  localparam logic [3:0] KIND_DELIVER  = 4'd0;
  localparam logic [3:0] KIND_OLD_DROP = 4'd1;
  localparam logic [3:0] KIND_DUP_DROP = 4'd2;
  localparam logic [3:0] KIND_STORED   = 4'd3;
  localparam logic [3:0] KIND_CLOSED   = 4'd4;
  localparam logic [3:0] KIND_FULL     = 4'd5;
  localparam logic [3:0] KIND_EMPTY    = 4'd6;
  localparam logic [3:0] KIND_NOT_OPEN = 4'd7;
  localparam logic [3:0] KIND_FIN_IGN  = 4'd8;
  localparam logic [3:0] KIND_FIN_PEND = 4'd9;
  localparam logic [3:0] KIND_OPENED   = 4'd10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] seq;
    logic [15:0] length;
    logic [7:0]  buffer_handle;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  out_handle;
    logic [15:0] out_length;
    logic [31:0] out_seq;
    logic        size_mismatch;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_RD, ST_CMP, ST_RESOLVE, ST_EMIT_LAST, ST_EMIT_MORE, ST_DRAIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_OPEN, OP_RESULT, OP_FIN_CLOSE, OP_DELIVER_IN, OP_SCAN_SEQ,
    OP_SCAN_CMP, OP_STORE, OP_DRAIN, OP_DRAIN_CLOSE, OP_EMIT
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t     op;
    logic [3:0] kind;
    logic       last;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       open;
    logic       len_zero;
    logic       old;
    logic       at_exp;
    logic       cmp_hit;
    logic       idx_last;
    logic       hit;
    logic       hit_fin;
    logic       free_found;
    logic       out_free;
  } dp_status_t;

endpackage

// File: hdl/tsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tsr_ctrl.sv
// Controller state machine of the reassembly unit.
// Depends on tsr_pkg; drives the datapath through ctl_cmd_t.
module tsr_ctrl
  import tsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctl_cmd_t   ctl
);

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;
  logic   inorder;

  // An in-order data segment starts a drain of cached entries.
  assign inorder = (sts.cmd == CMD_DATA) && sts.open && !sts.len_zero && !sts.old && sts.at_exp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
          drain_nxt = 1'b0;
        end
      end
      ST_DECIDE: begin
        if (sts.cmd == CMD_OPEN) begin
          state_nxt = ST_EMIT_LAST;
        end else if (sts.cmd == CMD_DATA) begin
          if (!sts.open || sts.len_zero || sts.old) begin
            state_nxt = ST_EMIT_LAST;
          end else begin
            state_nxt = ST_RD;
            drain_nxt = sts.at_exp;
          end
        end else if (sts.cmd == CMD_FIN) begin
          state_nxt = (!sts.open || sts.at_exp) ? ST_EMIT_LAST : ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: state_nxt = (sts.cmp_hit || sts.idx_last) ? ST_RESOLVE : ST_RD;
      ST_RESOLVE: state_nxt = (drain_r && sts.hit) ? ST_EMIT_MORE : ST_EMIT_LAST;
      ST_EMIT_LAST: if (sts.out_free) state_nxt = ST_IDLE;
      ST_EMIT_MORE: if (sts.out_free) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = sts.hit_fin ? ST_EMIT_LAST : ST_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: datapath command and input ready.
  always_comb begin
    ctl.op   = OP_NONE;
    ctl.kind = KIND_DELIVER;
    ctl.last = 1'b0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = OP_LOAD;
      end
      ST_DECIDE: begin
        if (sts.cmd == CMD_OPEN) begin
          ctl.op = OP_OPEN;
        end else if (!sts.open) begin
          if (sts.cmd != CMD_UNUSED) begin
            ctl.op   = OP_RESULT;
            ctl.kind = KIND_NOT_OPEN;
          end
        end else if (sts.cmd == CMD_DATA) begin
          if (sts.len_zero) begin
            ctl.op   = OP_RESULT;
            ctl.kind = KIND_EMPTY;
          end else if (sts.old) begin
            ctl.op   = OP_RESULT;
            ctl.kind = KIND_OLD_DROP;
          end else if (inorder) begin
            ctl.op   = OP_DELIVER_IN;
            ctl.kind = KIND_DELIVER;
          end else begin
            ctl.op = OP_SCAN_SEQ;
          end
        end else if (sts.cmd == CMD_FIN) begin
          if (sts.at_exp) begin
            ctl.op   = OP_FIN_CLOSE;
            ctl.kind = KIND_CLOSED;
          end else begin
            ctl.op = OP_SCAN_SEQ;
          end
        end
      end
      ST_RD: ctl.op = OP_NONE;
      ST_CMP: ctl.op = OP_SCAN_CMP;
      ST_RESOLVE: begin
        if (drain_r) begin
          ctl.op = OP_NONE;
        end else if (sts.hit) begin
          if (sts.cmd == CMD_DATA) begin
            ctl.op   = OP_RESULT;
            ctl.kind = KIND_DUP_DROP;
          end else if (sts.hit_fin) begin
            ctl.op   = OP_RESULT;
            ctl.kind = KIND_FIN_IGN;
          end else begin
            ctl.op   = OP_FIN_CLOSE;
            ctl.kind = KIND_CLOSED;
          end
        end else if (sts.free_found) begin
          ctl.op   = OP_STORE;
          ctl.kind = (sts.cmd == CMD_DATA) ? KIND_STORED : KIND_FIN_PEND;
        end else begin
          ctl.op   = OP_RESULT;
          ctl.kind = KIND_FULL;
        end
      end
      ST_EMIT_LAST: begin
        if (sts.out_free) begin
          ctl.op   = OP_EMIT;
          ctl.last = 1'b1;
        end
      end
      ST_EMIT_MORE: begin
        if (sts.out_free) ctl.op = OP_EMIT;
      end
      ST_DRAIN: ctl.op = sts.hit_fin ? OP_DRAIN_CLOSE : OP_DRAIN;
      default: ctl.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/tsr_dp.sv
// Datapath of the reassembly unit: request registers, stream state,
// entry table with valid bits, scan logic and output register.
// Depends on tsr_pkg and tsr_ram.
module tsr_dp
  import tsr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctl_cmd_t   ctl,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW = (HANDLE_BITS < 8) ? HANDLE_BITS : 8;
  localparam int EW = 32 + 16 + HW;

  // Request registers.
  logic [1:0]    cmd_r;
  logic [31:0]   seq_r;
  logic [15:0]   len_r;
  logic [HW-1:0] h_r;

  // Stream and scan state.
  logic [31:0]          exp_r;
  logic                 open_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0]          key_r;
  logic [IW-1:0]        idx_r;
  logic                 hit_r;
  logic [IW-1:0]        hit_idx_r;
  logic [31:0]          hit_seq_r;
  logic [15:0]          hit_len_r;
  logic [HW-1:0]        hit_h_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_idx_r;
  out_item_t            res_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [EW-1:0] rdata, wdata;
  logic          we;
  logic [31:0]   rd_seq;
  logic [15:0]   rd_len;
  logic [HW-1:0] rd_h;
  logic          cmp_hit, idx_last, is_fin, scan_reset;
  logic [31:0]   adv_in, adv_hit, seq_diff;
  out_item_t     simple_res;

  tsr_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(free_idx_r),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign rd_seq   = rdata[EW-1 -: 32];
  assign rd_len   = rdata[HW+15 : HW];
  assign rd_h     = rdata[HW-1:0];
  assign is_fin   = (cmd_r == CMD_FIN);
  assign cmp_hit  = valid_r[idx_r] && (rd_seq == key_r);
  assign idx_last = (idx_r == IW'(TABLE_DEPTH - 1));
  assign adv_in   = exp_r + 32'(len_r);
  assign adv_hit  = exp_r + 32'(hit_len_r);
  assign seq_diff = seq_r - exp_r;
  assign scan_reset = (ctl.op == OP_DELIVER_IN) || (ctl.op == OP_SCAN_SEQ) ||
                      (ctl.op == OP_DRAIN);

  // Table write: a stored segment or a FIN marker with zero length.
  assign we    = (ctl.op == OP_STORE);
  assign wdata = {seq_r, (is_fin ? 16'd0 : len_r), (is_fin ? {HW{1'b0}} : h_r)};

  // Result built from the request registers for single results.
  always_comb begin
    simple_res.kind = ctl.kind;
    if ((ctl.kind == KIND_CLOSED) || (ctl.kind == KIND_FIN_IGN) ||
        (ctl.kind == KIND_FIN_PEND) || (ctl.kind == KIND_OPENED)) begin
      simple_res.out_handle = 8'd0;
    end else begin
      simple_res.out_handle = 8'(h_r);
    end
    simple_res.out_length    = is_fin ? 16'd0 : len_r;
    simple_res.out_seq       = seq_r;
    simple_res.size_mismatch = (ctl.kind == KIND_DUP_DROP) && (hit_len_r != len_r);
    simple_res.last          = 1'b0;
  end

  // Status toward the controller.
  always_comb begin
    sts.cmd        = cmd_r;
    sts.open       = open_r;
    sts.len_zero   = (len_r == 16'd0);
    sts.old        = seq_diff[31];
    sts.at_exp     = (seq_r == exp_r);
    sts.cmp_hit    = cmp_hit;
    sts.idx_last   = idx_last;
    sts.hit        = hit_r;
    sts.hit_fin    = (hit_len_r == 16'd0);
    sts.free_found = free_found_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Control state: stream, valid bits, scan flags and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r        <= 32'd0;
      open_r       <= 1'b0;
      valid_r      <= '0;
      idx_r        <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (scan_reset) begin
        idx_r        <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end
      case (ctl.op)
        OP_OPEN: begin
          valid_r <= '0;
          exp_r   <= seq_r + 32'd1;
          open_r  <= 1'b1;
        end
        OP_FIN_CLOSE, OP_DRAIN_CLOSE: begin
          valid_r <= '0;
          open_r  <= 1'b0;
        end
        OP_DELIVER_IN: exp_r <= adv_in;
        OP_SCAN_CMP: begin
          if (cmp_hit) begin
            hit_r <= 1'b1;
          end else begin
            if (!valid_r[idx_r] && !free_found_r) free_found_r <= 1'b1;
            if (!idx_last) idx_r <= idx_r + IW'(1);
          end
        end
        OP_STORE: valid_r[free_idx_r] <= 1'b1;
        OP_DRAIN: begin
          exp_r              <= adv_hit;
          valid_r[hit_idx_r] <= 1'b0;
        end
        default: ;
      endcase
      if (ctl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r <= in_data.cmd;
        seq_r <= in_data.seq;
        len_r <= in_data.length;
        h_r   <= in_data.buffer_handle[HW-1:0];
      end
      OP_OPEN: res_r <= {KIND_OPENED, 8'd0, 16'd0, seq_r + 32'd1, 1'b0, 1'b0};
      OP_RESULT, OP_FIN_CLOSE, OP_STORE: res_r <= simple_res;
      OP_DELIVER_IN: begin
        res_r <= simple_res;
        key_r <= adv_in;
      end
      OP_SCAN_SEQ: key_r <= seq_r;
      OP_SCAN_CMP: begin
        if (cmp_hit) begin
          hit_idx_r <= idx_r;
          hit_seq_r <= rd_seq;
          hit_len_r <= rd_len;
          hit_h_r   <= rd_h;
        end else if (!valid_r[idx_r] && !free_found_r) begin
          free_idx_r <= idx_r;
        end
      end
      OP_DRAIN: begin
        res_r <= {KIND_DELIVER, 8'(hit_h_r), hit_len_r, hit_seq_r, 1'b0, 1'b0};
        key_r <= adv_hit;
      end
      OP_DRAIN_CLOSE: res_r <= {KIND_CLOSED, 8'd0, 16'd0, exp_r, 1'b0, 1'b0};
      OP_EMIT: out_data_r <= {res_r[$bits(out_item_t)-1:1], ctl.last};
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A close leaves an empty table and a closed stream.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_FIN_CLOSE || ctl.op == OP_DRAIN_CLOSE) |=> (valid_r == '0 && !open_r))
    else $error("close did not clear the table");

  // A result is never loaded over one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT) |-> (!out_valid_r || out_ready))
    else $error("result overwritten in output register");

  // A store goes only to a free slot found by the scan.
  a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_STORE) |-> (free_found_r && !valid_r[free_idx_r]))
    else $error("store into an occupied slot");
`endif

endmodule

// File: hdl/tcp_segment_reassembly_unit.sv
// Top level of the TCP segment reassembly unit.
// Depends on tsr_pkg, tsr_ctrl and tsr_dp (which holds tsr_ram).
//
//   Channel  Ports                        Carries
//   in       in_valid/in_ready/in_data    one descriptor request (in_item_t)
//   out      out_valid/out_ready/out_data one result item (out_item_t)
//
// A request without a table scan passes IDLE, DECIDE and EMIT_LAST; one with a
// scan also reads (ST_RD) and compares (ST_CMP) table entries in turn and
// then resolves; a scan stops at the first match or after TABLE_DEPTH entries.
// Each drained entry adds the EMIT_MORE and DRAIN states and one more scan.
// The result register lets a new request be taken while the last result waits.
// Reset is synchronous on rst_n and clears the stream and the table at once.
module tcp_segment_reassembly_unit
  import tsr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctl_cmd_t   ctl;
  dp_status_t sts;

  tsr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  tsr_dp #(.TABLE_DEPTH(TABLE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for tcp_segment_reassembly_unit.
// Depends on tsr_pkg and the RTL; predicts every result of each accepted request.
module testbench;
  import tsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  tcp_segment_reassembly_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predicted stream state.
  logic [31:0] exp_point;
  logic        is_open;
  logic        slot_used [DEPTH];
  logic [31:0] slot_seq [DEPTH];
  logic [15:0] slot_len [DEPTH];
  logic [7:0]  slot_hdl [DEPTH];

  out_item_t pending_results[$];
  int        fail_count;
  int        idle_cycles;
  int        results_seen;
  int        requests_sent;
  bit        calm;

  function automatic out_item_t mk(logic [3:0] k, logic [7:0] h, logic [15:0] l,
                                   logic [31:0] s, logic m);
    out_item_t r;
    r.kind = k;
    r.out_handle = h;
    r.out_length = l;
    r.out_seq = s;
    r.size_mismatch = m;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int lookup_slot(logic [31:0] s);
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && slot_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic void drop_stream();
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    is_open = 1'b0;
  endfunction

  // Work out the results of one request and update the predicted state.
  function automatic void reassemble(in_item_t it);
    out_item_t r[$];
    int k;
    if (it.cmd == CMD_OPEN) begin
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      exp_point = it.seq + 32'd1;
      is_open = 1'b1;
      r.push_back(mk(KIND_OPENED, 8'd0, 16'd0, exp_point, 1'b0));
    end else if (it.cmd == CMD_DATA) begin
      if (!is_open) begin
        r.push_back(mk(KIND_NOT_OPEN, it.buffer_handle, it.length, it.seq, 1'b0));
      end else if (it.length == 0) begin
        r.push_back(mk(KIND_EMPTY, it.buffer_handle, 16'd0, it.seq, 1'b0));
      end else if (((it.seq - exp_point) & 32'h8000_0000) != 0) begin
        r.push_back(mk(KIND_OLD_DROP, it.buffer_handle, it.length, it.seq, 1'b0));
      end else if (it.seq == exp_point) begin
        r.push_back(mk(KIND_DELIVER, it.buffer_handle, it.length, it.seq, 1'b0));
        exp_point += 32'(it.length);
        forever begin
          k = lookup_slot(exp_point);
          if (k < 0) break;
          if (slot_len[k] == 0) begin
            r.push_back(mk(KIND_CLOSED, 8'd0, 16'd0, exp_point, 1'b0));
            drop_stream();
            break;
          end
          r.push_back(mk(KIND_DELIVER, slot_hdl[k], slot_len[k], slot_seq[k], 1'b0));
          exp_point += 32'(slot_len[k]);
          slot_used[k] = 1'b0;
        end
      end else begin
        k = lookup_slot(it.seq);
        if (k >= 0) begin
          r.push_back(mk(KIND_DUP_DROP, it.buffer_handle, it.length, it.seq,
                         slot_len[k] != it.length));
        end else begin
          k = free_slot();
          if (k < 0) begin
            r.push_back(mk(KIND_FULL, it.buffer_handle, it.length, it.seq, 1'b0));
          end else begin
            slot_used[k] = 1'b1;
            slot_seq[k] = it.seq;
            slot_len[k] = it.length;
            slot_hdl[k] = it.buffer_handle;
            r.push_back(mk(KIND_STORED, it.buffer_handle, it.length, it.seq, 1'b0));
          end
        end
      end
    end else if (it.cmd == CMD_FIN) begin
      if (!is_open) begin
        r.push_back(mk(KIND_NOT_OPEN, it.buffer_handle, 16'd0, it.seq, 1'b0));
      end else if (it.seq == exp_point) begin
        r.push_back(mk(KIND_CLOSED, 8'd0, 16'd0, it.seq, 1'b0));
        drop_stream();
      end else begin
        k = lookup_slot(it.seq);
        if (k >= 0) begin
          if (slot_len[k] == 0) begin
            r.push_back(mk(KIND_FIN_IGN, 8'd0, 16'd0, it.seq, 1'b0));
          end else begin
            r.push_back(mk(KIND_CLOSED, 8'd0, 16'd0, it.seq, 1'b0));
            drop_stream();
          end
        end else begin
          k = free_slot();
          if (k < 0) begin
            r.push_back(mk(KIND_FULL, it.buffer_handle, 16'd0, it.seq, 1'b0));
          end else begin
            slot_used[k] = 1'b1;
            slot_seq[k] = it.seq;
            slot_len[k] = 16'd0;
            slot_hdl[k] = 8'd0;
            r.push_back(mk(KIND_FIN_PEND, 8'd0, 16'd0, it.seq, 1'b0));
          end
        end
      end
    end
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) pending_results.push_back(r[i]);
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  // Send one request; valid holds until accepted.
  task automatic send(logic [1:0] c, logic [31:0] s, logic [15:0] l, logic [7:0] h);
    in_item_t it;
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.cmd = c;
    it.seq = s;
    it.length = l;
    it.buffer_handle = h;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    reassemble(it);
    requests_sent++;
  endtask

  // Result checker with random back-pressure on out_ready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result kind=%0d", out_data.kind);
          fail_count++;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (e.kind != out_data.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, out_data.kind);
            fail_count++;
          end
          if (e.out_handle != out_data.out_handle) begin
            $error("out_handle: expected %0h actual %0h", e.out_handle, out_data.out_handle);
            fail_count++;
          end
          if (e.out_length != out_data.out_length) begin
            $error("out_length: expected %0h actual %0h", e.out_length, out_data.out_length);
            fail_count++;
          end
          if (e.out_seq != out_data.out_seq) begin
            $error("out_seq: expected %0h actual %0h", e.out_seq, out_data.out_seq);
            fail_count++;
          end
          if (e.size_mismatch != out_data.size_mismatch) begin
            $error("size_mismatch: expected %0b actual %0b", e.size_mismatch,
                   out_data.size_mismatch);
            fail_count++;
          end
          if (e.last != out_data.last) begin
            $error("last: expected %0b actual %0b", e.last, out_data.last);
            fail_count++;
          end
        end
      end
      out_ready <= !roll_idle();
    end
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Directed: open, in-order, out-of-order drain, duplicates, FIN forms.
  task automatic test_directed();
    send(CMD_DATA, 32'h10, 16'd5, 8'hff);
    send(CMD_FIN, 32'h10, 16'd0, 8'h0f);
    send(CMD_UNUSED, 32'hffff_ffff, 16'hffff, 8'hff);
    send(CMD_OPEN, 32'hffff_fffe, 16'hffff, 8'haa);
    send(CMD_DATA, 32'hffff_ffff, 16'd0, 8'h55);
    send(CMD_DATA, 32'h0000_0009, 16'd4, 8'h02);
    send(CMD_DATA, 32'h0000_0009, 16'd7, 8'h03);
    send(CMD_DATA, 32'h0000_0009, 16'd4, 8'h04);
    send(CMD_FIN, 32'h0000_000d, 16'd0, 8'h00);
    send(CMD_FIN, 32'h0000_000d, 16'd0, 8'h00);
    send(CMD_DATA, 32'h0000_000d, 16'd3, 8'h05);
    send(CMD_DATA, 32'hffff_fff0, 16'd1, 8'h06);
    send(CMD_DATA, 32'hffff_ffff, 16'd10, 8'hff);
    send(CMD_OPEN, 32'h0, 16'd0, 8'h00);
    send(CMD_DATA, 32'h100, 16'hffff, 8'h11);
    send(CMD_FIN, 32'h100, 16'd0, 8'h00);
    send(CMD_OPEN, 32'h7fff_ffff, 16'd0, 8'h00);
    send(CMD_FIN, 32'h0, 16'd0, 8'h01);
    send(CMD_FIN, 32'h8000_0000, 16'd0, 8'h00);
  endtask

  // Fill the table and overflow it with both data and a FIN marker.
  task automatic test_table_full();
    send(CMD_OPEN, 32'h1000, 16'd0, 8'h00);
    for (int i = 0; i < DEPTH; i++)
      send(CMD_DATA, 32'h2000 + i * 32'h10, 16'h10, 8'(i));
    send(CMD_DATA, 32'h3000, 16'd8, 8'h77);
    send(CMD_FIN, 32'h4000, 16'd0, 8'h78);
    send(CMD_DATA, 32'h1001, 16'h0fff, 8'h79);
  endtask

  // Random segmented streams: mostly well-formed, shuffled, with noise.
  task automatic test_random_streams(int budget);
    logic [31:0] isn, s;
    int          nseg;
    logic [15:0] lens [12];
    int          ord  [12];
    int          t, j;
    int          stop;
    stop = requests_sent + budget;
    while (requests_sent < stop) begin
      isn = $urandom();
      nseg = $urandom_range(1, 11);
      send(CMD_OPEN, isn, 16'($urandom()), 8'($urandom()));
      s = isn + 1;
      for (int i = 0; i < nseg; i++) begin
        lens[i] = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 64));
        if (lens[i] == 0) lens[i] = 1;
        ord[i] = i;
      end
      for (int i = nseg - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = ord[i];
        ord[i] = ord[j];
        ord[j] = t;
      end
      for (int i = 0; i < nseg; i++) begin
        logic [31:0] ps;
        ps = s;
        for (int q = 0; q < ord[i]; q++) ps += 32'(lens[q]);
        case ($urandom_range(19))
          0: send(CMD_DATA, $urandom(), 16'($urandom()), 8'($urandom()));
          1: send(CMD_DATA, ps, 16'd0, 8'($urandom()));
          2: send(CMD_DATA, ps, lens[ord[i]] ^ 16'($urandom_range(1, 3)), 8'($urandom()));
          3: send(2'($urandom_range(3)), $urandom(), 16'($urandom()), 8'($urandom()));
          default: ;
        endcase
        send(CMD_DATA, ps, lens[ord[i]], 8'($urandom()));
        if ($urandom_range(7) == 0) begin
          send(CMD_DATA, ps, lens[ord[i]], 8'($urandom()));
        end
      end
      s = s;
      for (int q = 0; q < nseg; q++) s += 32'(lens[q]);
      if ($urandom_range(3) != 0) begin
        send(CMD_FIN, s, 16'($urandom()), 8'($urandom()));
      end
      if ($urandom_range(5) == 0) begin
        send(CMD_DATA, $urandom(), 16'($urandom()), 8'($urandom()));
      end
    end
  endtask

  initial begin
    int drain_wait;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    results_seen = 0;
    requests_sent = 0;
    calm = 1'b0;
    exp_point = '0;
    is_open = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_seq[i] = '0;
      slot_len[i] = '0;
      slot_hdl[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    calm = 1'b1;
    test_random_streams(120);
    calm = 1'b0;
    test_random_streams(240);
    in_valid <= 1'b0;

    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < STALL_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Covered %0d requests and %0d results across open, in-order, drain,",
             requests_sent, results_seen);
    $display("duplicate, FIN and table-full cases.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
